>>> rtl/gamepad_debounce_autorepeat_assert.svh
// Assertion macros shared by the gamepad debounce block.
`ifndef GAMEPAD_DEBOUNCE_AUTOREPEAT_ASSERT_SVH
`define GAMEPAD_DEBOUNCE_AUTOREPEAT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GDA_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("gamepad debounce: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define GDA_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("gamepad debounce: next-cycle check failed");

`endif

>>> rtl/gda_pkg.sv
`timescale 1ns / 1ps

package gda_pkg;

  localparam int BUTTON_BITS = 16;
  localparam int PAD_W = 16;
  localparam logic [PAD_W-1:0] BUTTON_MASK = PAD_W'((33'd1 << BUTTON_BITS) - 33'd1);

  localparam logic [PAD_W-1:0] BTN_UP    = 16'h0001;
  localparam logic [PAD_W-1:0] BTN_DOWN  = 16'h0002;
  localparam logic [PAD_W-1:0] BTN_LEFT  = 16'h0004;
  localparam logic [PAD_W-1:0] BTN_RIGHT = 16'h0008;
  localparam logic [PAD_W-1:0] BTN_A     = 16'h0010;
  localparam logic [PAD_W-1:0] BTN_START = 16'h0080;
  localparam logic [PAD_W-1:0] BTN_B     = 16'h0020;
  localparam logic [PAD_W-1:0] BTN_MODE  = 16'h0800;
  localparam logic [PAD_W-1:0] DPAD_MASK = 16'h000F;

  localparam logic [7:0] KEY_NONE   = 8'd0;
  localparam logic [7:0] KEY_UP     = 8'd82;
  localparam logic [7:0] KEY_DOWN   = 8'd81;
  localparam logic [7:0] KEY_LEFT   = 8'd80;
  localparam logic [7:0] KEY_RIGHT  = 8'd79;
  localparam logic [7:0] KEY_ENTER  = 8'd40;
  localparam logic [7:0] KEY_ESCAPE = 8'd41;
  localparam logic [7:0] KEY_MODE   = 8'd22;

  localparam logic [15:0] RST_SCAN_INTERVAL = 16'd2000;
  localparam logic [3:0]  RST_DEBOUNCE_HITS = 4'd3;
  localparam logic [23:0] RST_REPEAT_DELAY  = 24'd400000;
  localparam logic [23:0] RST_REPEAT_RATE   = 24'd200000;

  typedef enum logic {
    REQ_POLL  = 1'b0,
    REQ_CLEAR = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    CFG_SCAN_INTERVAL = 2'd0,
    CFG_DEBOUNCE_HITS = 2'd1,
    CFG_REPEAT_DELAY  = 2'd2,
    CFG_REPEAT_RATE   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    req_t             req_type;
    logic [31:0]      now_us;
    logic [PAD_W-1:0] pad_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       key_code;
    logic [PAD_W-1:0] stable_buttons;
  } out_item_t;

  typedef struct packed {
    logic [15:0] scan_interval_us;
    logic [3:0]  debounce_hits;
    logic [23:0] repeat_delay_us;
    logic [23:0] repeat_rate_us;
  } cfg_t;

  function automatic logic [7:0] dpad_code(input logic [PAD_W-1:0] bits);
    logic [7:0] k;
    k = KEY_NONE;
    if ((bits & BTN_UP) != '0) k = KEY_UP;
    else if ((bits & BTN_DOWN) != '0) k = KEY_DOWN;
    else if ((bits & BTN_LEFT) != '0) k = KEY_LEFT;
    else if ((bits & BTN_RIGHT) != '0) k = KEY_RIGHT;
    return k;
  endfunction

  function automatic logic [7:0] press_code(input logic [PAD_W-1:0] bits);
    logic [7:0] k;
    k = KEY_NONE;
    if ((bits & DPAD_MASK) != '0) k = dpad_code(bits);
    else if ((bits & BTN_A) != '0) k = KEY_ENTER;
    else if ((bits & BTN_START) != '0) k = KEY_ENTER;
    else if ((bits & BTN_B) != '0) k = KEY_ESCAPE;
    else if ((bits & BTN_MODE) != '0) k = KEY_MODE;
    return k;
  endfunction

endpackage

>>> rtl/gda_core.sv
`timescale 1ns / 1ps

module gda_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  gda_pkg::in_item_t   item,
  input  gda_pkg::cfg_t       cfg,
  output gda_pkg::out_item_t  result
);

  logic [31:0]              last_scan_time;
  logic [gda_pkg::PAD_W-1:0] candidate_word;
  logic [3:0]               same_count;
  logic [gda_pkg::PAD_W-1:0] stable_word;
  logic [31:0]              repeat_start;
  logic                     repeating;

  logic [31:0]              last_scan_time_next;
  logic [gda_pkg::PAD_W-1:0] candidate_word_next;
  logic [3:0]               same_count_next;
  logic [gda_pkg::PAD_W-1:0] stable_word_next;
  logic [31:0]              repeat_start_next;
  logic                     repeating_next;

  logic [gda_pkg::PAD_W-1:0] pad;
  logic [31:0]              since_scan;
  logic [31:0]              elapsed;
  logic                     scan_due;
  logic [4:0]               count_inc;
  logic [gda_pkg::PAD_W-1:0] rise;
  logic [7:0]               key;

  assign pad        = item.pad_bits & gda_pkg::BUTTON_MASK;
  assign since_scan = item.now_us - last_scan_time;
  assign elapsed    = item.now_us - repeat_start;
  assign scan_due   = since_scan >= {16'd0, cfg.scan_interval_us};
  assign count_inc  = {1'b0, same_count} + 5'd1;

  always_comb begin
    last_scan_time_next = last_scan_time;
    candidate_word_next = candidate_word;
    same_count_next     = same_count;
    stable_word_next    = stable_word;
    repeat_start_next   = repeat_start;
    repeating_next      = repeating;
    rise                = '0;
    key                 = gda_pkg::KEY_NONE;
    if (item.req_type == gda_pkg::REQ_CLEAR) begin
      last_scan_time_next = '0;
      candidate_word_next = '0;
      same_count_next     = '0;
      stable_word_next    = '0;
      repeat_start_next   = '0;
      repeating_next      = 1'b0;
    end else begin
      if (scan_due) begin
        last_scan_time_next = item.now_us;
        if (pad != candidate_word) begin
          candidate_word_next = pad;
          same_count_next     = 4'd1;
        end else if (count_inc < {1'b0, cfg.debounce_hits}) begin
          same_count_next = count_inc[3:0];
        end else begin
          same_count_next  = '0;
          rise             = pad & ~stable_word;
          stable_word_next = pad;
        end
      end
      if (rise != '0) begin
        repeating_next    = 1'b0;
        repeat_start_next = item.now_us;
        key               = gda_pkg::press_code(rise);
      end else if ((stable_word_next & gda_pkg::DPAD_MASK) != '0) begin
        if (repeating) begin
          if (elapsed >= {8'd0, cfg.repeat_rate_us}) begin
            repeat_start_next = item.now_us;
            key               = gda_pkg::dpad_code(stable_word_next);
          end
        end else if (elapsed >= {8'd0, cfg.repeat_delay_us}) begin
          repeat_start_next = item.now_us;
          repeating_next    = 1'b1;
          key               = gda_pkg::dpad_code(stable_word_next);
        end
      end
    end
    result.key_code       = key;
    result.stable_buttons = stable_word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_scan_time <= '0;
      candidate_word <= '0;
      same_count     <= '0;
      stable_word    <= '0;
      repeat_start   <= '0;
      repeating      <= 1'b0;
    end else if (step) begin
      last_scan_time <= last_scan_time_next;
      candidate_word <= candidate_word_next;
      same_count     <= same_count_next;
      stable_word    <= stable_word_next;
      repeat_start   <= repeat_start_next;
      repeating      <= repeating_next;
    end
  end

endmodule

>>> rtl/gamepad_debounce_autorepeat.sv
`timescale 1ns / 1ps
// Gamepad button debounce with D-pad autorepeat.
// Input channel in_valid/in_stall/in_item carries one poll per item: a
// request type, a microsecond time stamp and a raw button scan. Output channel
// out_valid/out_stall/out_item returns exactly one item per poll with a HID
// key code and the debounced button word, in poll order.
// The configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the
// scan interval, debounce count, repeat delay and repeat rate; cfg_ready is
// always high and writes are meant for times when no poll is in flight.
// A poll accepted at one clock edge is registered in the input register, processed against
// the pad state once the output can take it, and its result is then registered in the
// output register. One poll is accepted every cycle while in_stall is low, set by the single
// compare-and-update pass over the pad state registers.
// When the receiver stalls, the result holds in the output register and the
// input register, if empty, still takes one more poll before in_stall rises.
// Reset clears the pad state, both channels and restores the default
// configuration. A clear request resets the pad state without touching the configuration.

module gamepad_debounce_autorepeat (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  gda_pkg::in_item_t     in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output gda_pkg::out_item_t    out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  gda_pkg::cfg_idx_t     cfg_index,
  input  logic [23:0]           cfg_data
);

  gda_pkg::cfg_t      cfg;
  gda_pkg::in_item_t  s1_item;
  gda_pkg::out_item_t core_result;
  logic               s1_valid;
  logic               advance;
  logic               in_fire;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_interval_us <= gda_pkg::RST_SCAN_INTERVAL;
      cfg.debounce_hits    <= gda_pkg::RST_DEBOUNCE_HITS;
      cfg.repeat_delay_us  <= gda_pkg::RST_REPEAT_DELAY;
      cfg.repeat_rate_us   <= gda_pkg::RST_REPEAT_RATE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gda_pkg::CFG_SCAN_INTERVAL: cfg.scan_interval_us <= cfg_data[15:0];
        gda_pkg::CFG_DEBOUNCE_HITS: cfg.debounce_hits    <= cfg_data[3:0];
        gda_pkg::CFG_REPEAT_DELAY:  cfg.repeat_delay_us  <= cfg_data;
        gda_pkg::CFG_REPEAT_RATE:   cfg.repeat_rate_us   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item <= in_item;
    end
  end

  gda_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (s1_item),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= core_result;
    end
  end

`include "gamepad_debounce_autorepeat_assert.svh"

  `GDA_ASSERT_NOW(a_stall_needs_item, clk, rst, in_stall, s1_valid)
  `GDA_ASSERT_NEXT(a_clear_gives_zero, clk, rst,
    advance && (s1_item.req_type == gda_pkg::REQ_CLEAR),
    out_valid && (out_item.key_code == gda_pkg::KEY_NONE) && (out_item.stable_buttons == '0))
  `GDA_ASSERT_NOW(a_key_needs_buttons, clk, rst,
    out_valid && (out_item.key_code != gda_pkg::KEY_NONE), out_item.stable_buttons != '0)

endmodule

>>> tb/tb_gamepad_debounce_autorepeat.sv
`timescale 1ns / 1ps

module tb_gamepad_debounce_autorepeat;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int N_PROBES = 26;
  localparam int LOW_CFG_ROW = 8;
  localparam int N_PHASES = 8;
  localparam int PHASE_POLLS = 250;

  typedef struct packed {
    gda_pkg::req_t req;
    logic [31:0]   now;
    logic [15:0]   pad;
    logic          typed;
    logic [7:0]    key;
    logic [15:0]   stable;
  } probe_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  gda_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gda_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  gda_pkg::cfg_idx_t cfg_index = gda_pkg::CFG_SCAN_INTERVAL;
  logic [23:0] cfg_data = '0;

  gda_pkg::cfg_t pad_cfg = '{gda_pkg::RST_SCAN_INTERVAL, gda_pkg::RST_DEBOUNCE_HITS,
                             gda_pkg::RST_REPEAT_DELAY, gda_pkg::RST_REPEAT_RATE};
  logic [31:0] last_scan_at = '0;
  logic [15:0] cand_word = '0;
  logic [3:0] cand_hits = '0;
  logic [15:0] stable_now = '0;
  logic [31:0] hold_since = '0;
  logic auto_on = 1'b0;

  gda_pkg::out_item_t pending[$];
  gda_pkg::out_item_t want_item;
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  int unsigned next_stall;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  gamepad_debounce_autorepeat uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] key_for(input logic [15:0] bits, input bit dpad_only);
    if ((bits & gda_pkg::BTN_UP) != '0) return gda_pkg::KEY_UP;
    if ((bits & gda_pkg::BTN_DOWN) != '0) return gda_pkg::KEY_DOWN;
    if ((bits & gda_pkg::BTN_LEFT) != '0) return gda_pkg::KEY_LEFT;
    if ((bits & gda_pkg::BTN_RIGHT) != '0) return gda_pkg::KEY_RIGHT;
    if (dpad_only) return gda_pkg::KEY_NONE;
    if ((bits & gda_pkg::BTN_A) != '0) return gda_pkg::KEY_ENTER;
    if ((bits & gda_pkg::BTN_START) != '0) return gda_pkg::KEY_ENTER;
    if ((bits & gda_pkg::BTN_B) != '0) return gda_pkg::KEY_ESCAPE;
    if ((bits & gda_pkg::BTN_MODE) != '0) return gda_pkg::KEY_MODE;
    return gda_pkg::KEY_NONE;
  endfunction

  // Advances the pad state by one poll and returns the key and debounced word it yields.
  function automatic gda_pkg::out_item_t debounce_step(input gda_pkg::in_item_t it);
    logic [15:0] pad;
    logic [15:0] rise;
    logic [15:0] dpad;
    logic [4:0] next_hits;
    gda_pkg::out_item_t r;
    pad = it.pad_bits & gda_pkg::BUTTON_MASK;
    rise = '0;
    r.key_code = gda_pkg::KEY_NONE;
    if (it.req_type == gda_pkg::REQ_CLEAR) begin
      last_scan_at = '0;
      cand_word = '0;
      cand_hits = '0;
      stable_now = '0;
      hold_since = '0;
      auto_on = 1'b0;
      r.stable_buttons = '0;
      return r;
    end
    if (it.now_us - last_scan_at >= {16'b0, pad_cfg.scan_interval_us}) begin
      last_scan_at = it.now_us;
      if (pad != cand_word) begin
        cand_word = pad;
        cand_hits = 4'd1;
      end else begin
        next_hits = {1'b0, cand_hits} + 5'd1;
        if (next_hits < {1'b0, pad_cfg.debounce_hits}) begin
          cand_hits = next_hits[3:0];
        end else begin
          cand_hits = '0;
          rise = pad & ~stable_now;
          stable_now = pad;
        end
      end
    end
    if (rise != '0 && stable_now != '0) begin
      auto_on = 1'b0;
      hold_since = it.now_us;
      r.key_code = key_for(rise, 1'b0);
    end else if (stable_now != '0) begin
      dpad = stable_now & gda_pkg::DPAD_MASK;
      if (dpad != '0) begin
        if (auto_on) begin
          if (it.now_us - hold_since >= {8'b0, pad_cfg.repeat_rate_us}) begin
            hold_since = it.now_us;
            r.key_code = key_for(dpad, 1'b1);
          end
        end else if (it.now_us - hold_since >= {8'b0, pad_cfg.repeat_delay_us}) begin
          hold_since = it.now_us;
          auto_on = 1'b1;
          r.key_code = key_for(dpad, 1'b1);
        end
      end
    end
    r.stable_buttons = stable_now;
    return r;
  endfunction

  function automatic probe_t probe_at(input int i);
    case (i)
      0: return '{gda_pkg::REQ_POLL, 32'd0, 16'h0000, 1'b1, gda_pkg::KEY_NONE, 16'h0000};
      1: return '{gda_pkg::REQ_POLL, 32'd1999, gda_pkg::BTN_UP, 1'b0, gda_pkg::KEY_NONE, 16'h0};
      2: return '{gda_pkg::REQ_POLL, 32'd2000, gda_pkg::BTN_UP, 1'b0, gda_pkg::KEY_NONE, 16'h0};
      3: return '{gda_pkg::REQ_POLL, 32'd4000, gda_pkg::BTN_UP, 1'b0, gda_pkg::KEY_NONE, 16'h0};
      4: return '{gda_pkg::REQ_POLL, 32'd6000, gda_pkg::BTN_UP, 1'b1, gda_pkg::KEY_UP,
                  gda_pkg::BTN_UP};
      5: return '{gda_pkg::REQ_POLL, 32'd406000, gda_pkg::BTN_UP, 1'b0, gda_pkg::KEY_NONE,
                  16'h0};
      6: return '{gda_pkg::REQ_POLL, 32'd606000, gda_pkg::BTN_UP, 1'b0, gda_pkg::KEY_NONE,
                  16'h0};
      7: return '{gda_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, gda_pkg::KEY_NONE,
                  16'h0000};
      8: return '{gda_pkg::REQ_POLL, 32'd100, gda_pkg::BTN_DOWN, 1'b0, gda_pkg::KEY_NONE, 16'h0};
      9: return '{gda_pkg::REQ_POLL, 32'd101, gda_pkg::BTN_DOWN, 1'b0, gda_pkg::KEY_NONE, 16'h0};
      10: return '{gda_pkg::REQ_POLL, 32'd102, gda_pkg::BTN_LEFT, 1'b0, gda_pkg::KEY_NONE, 16'h0};
      11: return '{gda_pkg::REQ_POLL, 32'd103, gda_pkg::BTN_LEFT, 1'b0, gda_pkg::KEY_NONE, 16'h0};
      12: return '{gda_pkg::REQ_POLL, 32'd104, gda_pkg::BTN_RIGHT, 1'b0, gda_pkg::KEY_NONE,
                   16'h0};
      13: return '{gda_pkg::REQ_POLL, 32'd105, gda_pkg::BTN_RIGHT, 1'b0, gda_pkg::KEY_NONE,
                   16'h0};
      14: return '{gda_pkg::REQ_POLL, 32'd106, gda_pkg::BTN_A, 1'b0, gda_pkg::KEY_NONE, 16'h0};
      15: return '{gda_pkg::REQ_POLL, 32'd107, gda_pkg::BTN_A, 1'b0, gda_pkg::KEY_NONE, 16'h0};
      16: return '{gda_pkg::REQ_POLL, 32'd108, gda_pkg::BTN_START, 1'b0, gda_pkg::KEY_NONE,
                   16'h0};
      17: return '{gda_pkg::REQ_POLL, 32'd109, gda_pkg::BTN_START, 1'b0, gda_pkg::KEY_NONE,
                   16'h0};
      18: return '{gda_pkg::REQ_POLL, 32'd110, gda_pkg::BTN_B, 1'b0, gda_pkg::KEY_NONE, 16'h0};
      19: return '{gda_pkg::REQ_POLL, 32'd111, gda_pkg::BTN_B, 1'b0, gda_pkg::KEY_NONE, 16'h0};
      20: return '{gda_pkg::REQ_POLL, 32'd112, gda_pkg::BTN_MODE, 1'b0, gda_pkg::KEY_NONE, 16'h0};
      21: return '{gda_pkg::REQ_POLL, 32'd113, gda_pkg::BTN_MODE, 1'b0, gda_pkg::KEY_NONE, 16'h0};
      22: return '{gda_pkg::REQ_POLL, 32'd114, 16'h0040, 1'b0, gda_pkg::KEY_NONE, 16'h0000};
      23: return '{gda_pkg::REQ_POLL, 32'd115, 16'h0040, 1'b0, gda_pkg::KEY_NONE, 16'h0000};
      24: return '{gda_pkg::REQ_POLL, 32'd116, 16'hFFFF, 1'b0, gda_pkg::KEY_NONE, 16'h0000};
      default: return '{gda_pkg::REQ_POLL, 32'd117, 16'hFFFF, 1'b1, gda_pkg::KEY_UP, 16'hFFFF};
    endcase
  endfunction

  function automatic int unsigned idle_len(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= 32) begin
      $display("result %0d: %s got 0x%0h expected 0x%0h", results_seen, what, got, want);
    end
  endtask

  task automatic send_poll(input gda_pkg::in_item_t it, input bit typed,
                           input gda_pkg::out_item_t want);
    int unsigned gap;
    gda_pkg::out_item_t predicted;
    gap = idle_len(send_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    predicted = debounce_step(it);
    pending.push_back(typed ? want : predicted);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input gda_pkg::cfg_idx_t idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input gda_pkg::cfg_t c);
    write_reg(gda_pkg::CFG_SCAN_INTERVAL, {8'b0, c.scan_interval_us});
    write_reg(gda_pkg::CFG_DEBOUNCE_HITS, {20'b0, c.debounce_hits});
    write_reg(gda_pkg::CFG_REPEAT_DELAY, c.repeat_delay_us);
    write_reg(gda_pkg::CFG_REPEAT_RATE, c.repeat_rate_us);
    cfg_valid <= 1'b0;
    pad_cfg = c;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[gamepad_debounce_autorepeat] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(out_item), 32'd0);
        end else begin
          want_item = pending.pop_front();
          if (out_item.key_code !== want_item.key_code) begin
            report_mismatch("key_code", 32'(out_item.key_code), 32'(want_item.key_code));
          end
          if (out_item.stable_buttons !== want_item.stable_buttons) begin
            report_mismatch("stable_buttons", 32'(out_item.stable_buttons),
                            32'(want_item.stable_buttons));
          end
        end
        results_seen++;
      end
      if (cycle_count[7:0] == 8'd0) begin
        recv_calm <= ($urandom_range(0, 3) == 0);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        next_stall = idle_len(recv_calm);
        out_stall <= (next_stall != 0);
        stall_left <= (next_stall == 0) ? 0 : next_stall - 1;
      end
    end
  end

  initial begin
    probe_t p;
    gda_pkg::in_item_t it;
    gda_pkg::cfg_t c;
    logic [31:0] now;
    logic [31:0] iv;
    logic [15:0] held;
    int unsigned hold_left;
    int unsigned hits_eff;
    int unsigned r;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_PROBES; i++) begin
      if (i == LOW_CFG_ROW) begin
        drain();
        program_regs('{16'd0, 4'd0, 24'd0, 24'd0});
      end
      p = probe_at(i);
      it.req_type = p.req;
      it.now_us = p.now;
      it.pad_bits = p.pad;
      send_poll(it, p.typed, '{p.key, p.stable});
    end

    held = '0;
    hold_left = 0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        0: c = '{gda_pkg::RST_SCAN_INTERVAL, gda_pkg::RST_DEBOUNCE_HITS,
                 gda_pkg::RST_REPEAT_DELAY, gda_pkg::RST_REPEAT_RATE};
        1: c = '{16'hFFFF, 4'hF, 24'hFFFFFF, 24'hFFFFFF};
        2: c = '{16'd0, 4'd1, 24'd0, 24'd0};
        3: c = '{16'd100, 4'd2, 24'd3000, 24'd1000};
        4: c = '{16'd50, 4'd4, 24'd500, 24'd200};
        default: begin
          c.scan_interval_us = 16'($urandom_range(0, 300));
          c.debounce_hits = 4'($urandom_range(1, 15));
          c.repeat_delay_us = 24'($urandom_range(0, 5000));
          c.repeat_rate_us = 24'($urandom_range(0, 3000));
        end
      endcase
      program_regs(c);
      now = (ph == 3) ? 32'hFFFF_8000 : $urandom();
      iv = {16'b0, pad_cfg.scan_interval_us};
      hits_eff = (pad_cfg.debounce_hits == 0) ? 1 : pad_cfg.debounce_hits;
      for (int n = 0; n < PHASE_POLLS; n++) begin
        if (n % 100 == 0) send_calm = ($urandom_range(0, 4) == 0);
        if (hold_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 10) begin
            held = '0;
          end else if (r < 45) begin
            case ($urandom_range(0, 9))
              0: held = gda_pkg::BTN_UP;
              1: held = gda_pkg::BTN_DOWN;
              2: held = gda_pkg::BTN_LEFT;
              3: held = gda_pkg::BTN_RIGHT;
              4: held = gda_pkg::BTN_A;
              5: held = gda_pkg::BTN_START;
              6: held = gda_pkg::BTN_B;
              7: held = gda_pkg::BTN_MODE;
              8: held = 16'h0040;
              default: held = 16'h8000;
            endcase
          end else if (r < 65) begin
            held = 16'($urandom_range(1, 15));
          end else if (r < 85) begin
            held = held ^ (16'h1 << $urandom_range(0, 15));
          end else begin
            held = 16'($urandom());
          end
          r = $urandom_range(0, 99);
          if (r < 45) hold_left = $urandom_range(1, 3);
          else if (r < 85) hold_left = $urandom_range(hits_eff + 1, hits_eff + 6);
          else hold_left = $urandom_range(hits_eff + 8, hits_eff + 50);
        end
        hold_left--;
        it.pad_bits = ($urandom_range(0, 99) < 8) ? 16'($urandom()) : held;
        r = $urandom_range(0, 99);
        if (r < 15) now = now + $urandom_range(0, iv);
        else if (r < 85) now = now + iv + $urandom_range(0, iv / 4 + 3);
        else if (r < 97) now = now + $urandom_range(0, pad_cfg.repeat_rate_us + 16);
        else now = now + $urandom();
        it.now_us = now;
        it.req_type = ($urandom_range(0, 99) < 2) ? gda_pkg::REQ_CLEAR : gda_pkg::REQ_POLL;
        send_poll(it, 1'b0, '0);
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("[gamepad_debounce_autorepeat] OK");
    end else begin
      $display("[gamepad_debounce_autorepeat] ERROR");
    end
    $finish;
  end

endmodule
